/* rtl/constant_velocity_kalman_3d_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the constant-velocity Kalman filter
// Shared property shapes, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_VELOCITY_KALMAN_3D_ASSERT_SVH
`define CONSTANT_VELOCITY_KALMAN_3D_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KCV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define KCV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/kcv_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcv_pkg
// Types, widths and helper functions of the constant-velocity Kalman filter.
// ---------------------------------------------------------------------------
package kcv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int DT_W      = 20;
   localparam int CFG_W     = 32;
   localparam int COV_W     = 48;
   localparam int HALF_W    = COV_W / 2;
   localparam int PROD_W    = 2 * COV_W;
   localparam int PROD_BITS = 40;
   localparam int DEN_W     = COV_W + 1;
   localparam int DVD_W     = COV_W + FRAC_BITS;
   localparam int E_W       = POS_W + 1;
   localparam int SUM_W     = PROD_BITS + 2;
   localparam int ADDR_W    = 4;

   localparam logic [COV_W-1:0] COV_MAX  = {COV_W{1'b1}};
   localparam logic [COV_W-1:0] PROD_MAX = COV_W'({PROD_BITS{1'b1}});

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
   localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
   localparam logic [1:0] REG_INITIAL_ERROR     = 2'd2;

   localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 32'd66;
   localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;
   localparam logic [CFG_W-1:0] INITIAL_ERROR_RST     = 32'd65536;

   typedef struct packed {
      logic signed [POS_W-1:0] meas_x;
      logic signed [POS_W-1:0] meas_y;
      logic signed [POS_W-1:0] meas_z;
      logic        [DT_W-1:0]  time_step;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] est_x;
      logic signed [POS_W-1:0] est_y;
      logic signed [POS_W-1:0] est_z;
   } rsp_type;

   // command to the shared multiplier
   typedef struct packed {
      logic             start;
      logic             prod_cap;
      logic [COV_W-1:0] op_a;
      logic [COV_W-1:0] op_b;
   } mul_req_type;

   // command to the divider
   typedef struct packed {
      logic             start;
      logic [COV_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   // result of either arithmetic unit
   typedef struct packed {
      logic             done;
      logic [COV_W-1:0] value;
   } unit_rsp_type;

   function automatic logic [COV_W-1:0] cov_add(input logic [COV_W-1:0] a,
                                                input logic [COV_W-1:0] b);
      logic [COV_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COV_W] ? COV_MAX : s[COV_W-1:0];
   endfunction

   function automatic logic [COV_W-1:0] cov_sub(input logic [COV_W-1:0] a,
                                                input logic [COV_W-1:0] b);
      return (b >= a) ? '0 : a - b;
   endfunction

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
         r = v[POS_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [COV_W-1:0] mag(input logic signed [E_W-1:0] v);
      logic [E_W-1:0] m;
      m = v[E_W-1] ? -v : v;
      return COV_W'(m);
   endfunction

endpackage

/* rtl/kcv_mul.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcv_mul
// Shared 48x48 fixed-point multiplier: four 24x24 passes, then round to
// nearest (ties away) and saturate at the selected cap.
// ---------------------------------------------------------------------------
module kcv_mul import kcv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mul_req_type  mul_req,
   output unit_rsp_type mul_rsp
);

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              cap_ff, cap_in;
   logic [COV_W-1:0]  a_ff, a_in;
   logic [COV_W-1:0]  b_ff, b_in;
   logic [COV_W-1:0]  pp_ff, pp_in;
   logic [1:0]        sh_ff, sh_in;
   logic              pv_ff, pv_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [COV_W-1:0]  res_ff, res_in;

   logic [HALF_W-1:0] a_half, b_half;
   logic [COV_W-1:0]  pp_now;
   logic [PROD_W-1:0] pp_shifted, rnd;
   logic [COV_W-1:0]  cap, val;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      cap_in  = cap_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      pv_in   = 1'b0;
      acc_in  = acc_ff;
      res_in  = res_ff;

      a_half = cnt_ff[0] ? a_ff[COV_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_half = cnt_ff[1] ? b_ff[COV_W-1:HALF_W] : b_ff[HALF_W-1:0];
      // full-width 24x24 partial product
      pp_now = a_half * b_half;

      case (sh_ff)
         2'd0:    pp_shifted = PROD_W'(pp_ff);
         2'd1:    pp_shifted = PROD_W'(pp_ff) << HALF_W;
         default: pp_shifted = PROD_W'(pp_ff) << COV_W;
      endcase

      // rounding and saturation of the finished product
      rnd = acc_ff + ROUND_HALF;
      val = rnd[COV_W+FRAC_BITS-1:FRAC_BITS];
      cap = cap_ff ? PROD_MAX : COV_MAX;

      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         cap_in  = mul_req.prod_cap;
         a_in    = mul_req.op_a;
         b_in    = mul_req.op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         // partial products for counts 0..3, accumulated in the next cycle
         if (cnt_ff < 3'd4) begin
            pp_in = pp_now;
            sh_in = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
            pv_in = 1'b1;
         end
         if (pv_ff) begin
            acc_in = acc_ff + pp_shifted;
         end
         if (cnt_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (rnd[PROD_W-1:COV_W+FRAC_BITS] != '0 || val > cap) begin
               res_in = cap;
            end else begin
               res_in = val;
            end
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pv_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pv_ff   <= pv_in;
         cnt_ff  <= cnt_in;
      end
      cap_ff <= cap_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign mul_rsp.done  = done_ff;
   assign mul_rsp.value = res_ff;

endmodule

/* rtl/kcv_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcv_div
// Restoring divider for the gains: floor(num * 2^F / den), one quotient bit
// per cycle, saturated to the covariance range; zero divisor gives zero.
// ---------------------------------------------------------------------------
module kcv_div import kcv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  div_req,
   output unit_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [COV_W-1:0] res_ff, res_in;

   logic [DEN_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      res_in  = res_ff;

      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = {div_req.num, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            // final saturation
            busy_in = 1'b0;
            done_in = 1'b1;
            if (den_ff == '0) begin
               res_in = '0;
            end else if (quo_ff[DVD_W-1:COV_W] != '0) begin
               res_in = COV_MAX;
            end else begin
               res_in = quo_ff[COV_W-1:0];
            end
         end else begin
            // one shift-subtract step
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], ge};
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      res_ff <= res_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.value = res_ff;

endmodule

/* rtl/constant_velocity_kalman_3d.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// constant_velocity_kalman_3d
// Three-axis constant-velocity Kalman filter with one shared 2x2 covariance,
// run as a sequence of operations on one multiplier and one divider.
// ---------------------------------------------------------------------------
//   channel   ports                     direction  content
//   req       req_valid/stall/data      in         meas_x/y/z, time_step
//   rsp       rsp_valid/stall/data      out        est_x/y/z
//   csr       csr_p*                    in/out     noise and initial error
//
// An item runs to its end before the next one is accepted: 15 multiplies on
// the multiplier (four 24x24 passes per product) and two gain divisions in
// the bit-serial divider, then the result goes to the output register once
// it is free. The first item after reset skips the operations and is echoed
// straight to the output register.
// req_stall is high from acceptance until the result is loaded in the
// output register; a stalled result holds there while the next item runs.
// Synchronous reset clears the filter to its not-started state.
// ---------------------------------------------------------------------------
module constant_velocity_kalman_3d import kcv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CFG_W-1:0]  csr_pwdata,
   output logic [CFG_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_OUT} state_type;
   typedef enum logic [3:0] {
      OP_PB, OP_APV, OP_APB, OP_DKP, OP_DKV,
      OP_XP, OP_MKP, OP_MKV, OP_CPP, OP_CPV, OP_CVV
   } op_type;

   // configuration registers
   logic [CFG_W-1:0] q_ff, r_ff, p0_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff  <= PROCESS_NOISE_RST;
         r_ff  <= MEASUREMENT_NOISE_RST;
         p0_ff <= INITIAL_ERROR_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_PROCESS_NOISE:     q_ff  <= csr_pwdata;
            REG_MEASUREMENT_NOISE: r_ff  <= csr_pwdata;
            REG_INITIAL_ERROR:     p0_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_PROCESS_NOISE:     csr_prdata = q_ff;
         REG_MEASUREMENT_NOISE: csr_prdata = r_ff;
         REG_INITIAL_ERROR:     csr_prdata = p0_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // sequencer state
   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [1:0]              axis_ff, axis_in;
   logic                    started_ff, started_in;
   logic signed [POS_W-1:0] meas_ff [3];
   logic signed [POS_W-1:0] meas_in [3];
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W-1:0] pos_in [3];
   logic signed [POS_W-1:0] vel_ff [3];
   logic signed [POS_W-1:0] vel_in [3];
   logic [COV_W-1:0]        cpp_ff, cpp_in, cpv_ff, cpv_in, cvv_ff, cvv_in;
   logic [COV_W-1:0]        a_ff, a_in, pb_ff, pb_in, c_ff, c_in;
   logic [COV_W-1:0]        kp_ff, kp_in, kv_ff, kv_in;
   logic signed [POS_W-1:0] xp_ff, xp_in;
   logic signed [E_W-1:0]   e_ff, e_in;
   logic                    sgn_ff, sgn_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   mul_req_type  mul_req;
   div_req_type  div_req;
   unit_rsp_type mul_rsp, div_rsp;

   logic                    is_div, unit_done;
   logic [COV_W-1:0]        unit_val, q48, p048;
   logic signed [E_W-1:0]   vel_ext, e_now;
   logic signed [SUM_W-1:0] prod_mag, sprod;
   logic [DEN_W-1:0]        s_sum;

   kcv_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   kcv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign is_div    = (op_ff == OP_DKP) || (op_ff == OP_DKV);
   assign unit_done = is_div ? div_rsp.done : mul_rsp.done;
   assign unit_val  = is_div ? div_rsp.value : mul_rsp.value;

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      axis_in      = axis_ff;
      started_in   = started_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      cpp_in       = cpp_ff;
      cpv_in       = cpv_ff;
      cvv_in       = cvv_ff;
      a_in         = a_ff;
      pb_in        = pb_ff;
      c_in         = c_ff;
      kp_in        = kp_ff;
      kv_in        = kv_ff;
      xp_in        = xp_ff;
      e_in         = e_ff;
      sgn_in       = sgn_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;
      div_req      = '0;

      q48      = COV_W'(q_ff);
      p048     = COV_W'(p0_ff);
      vel_ext  = E_W'(vel_ff[axis_ff]);
      e_now    = E_W'(meas_ff[axis_ff]) - E_W'(xp_ff);
      s_sum    = {1'b0, a_ff} + DEN_W'(r_ff);
      prod_mag = $signed(SUM_W'(mul_rsp.value[PROD_BITS-1:0]));
      sprod    = sgn_ff ? -prod_mag : prod_mag;

      // operands of the current operation
      case (op_ff)
         OP_PB: begin
            mul_req.op_a = COV_W'(dt_ff);
            mul_req.op_b = cvv_ff;
         end
         OP_APV: begin
            mul_req.op_a = COV_W'(dt_ff);
            mul_req.op_b = cpv_ff;
         end
         OP_APB: begin
            mul_req.op_a = COV_W'(dt_ff);
            mul_req.op_b = pb_ff;
         end
         OP_DKP: begin
            div_req.num = a_ff;
            div_req.den = s_sum;
         end
         OP_DKV: begin
            div_req.num = pb_ff;
            div_req.den = s_sum;
         end
         OP_XP: begin
            mul_req.op_a     = mag(vel_ext);
            mul_req.op_b     = COV_W'(dt_ff);
            mul_req.prod_cap = 1'b1;
         end
         OP_MKP: begin
            mul_req.op_a     = mag(e_now);
            mul_req.op_b     = kp_ff;
            mul_req.prod_cap = 1'b1;
         end
         OP_MKV: begin
            mul_req.op_a     = mag(e_ff);
            mul_req.op_b     = kv_ff;
            mul_req.prod_cap = 1'b1;
         end
         OP_CPP: begin
            mul_req.op_a = kp_ff;
            mul_req.op_b = a_ff;
         end
         OP_CPV: begin
            mul_req.op_a = kp_ff;
            mul_req.op_b = pb_ff;
         end
         OP_CVV: begin
            mul_req.op_a = kv_ff;
            mul_req.op_b = pb_ff;
         end
         default: ;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in[0] = req_data.meas_x;
               meas_in[1] = req_data.meas_y;
               meas_in[2] = req_data.meas_z;
               dt_in      = req_data.time_step;
               if (!started_ff) begin
                  // first item loads the state and is echoed
                  pos_in[0]  = req_data.meas_x;
                  pos_in[1]  = req_data.meas_y;
                  pos_in[2]  = req_data.meas_z;
                  vel_in     = '{default: '0};
                  cpp_in     = p048;
                  cpv_in     = '0;
                  cvv_in     = p048;
                  started_in = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  op_in    = OP_PB;
                  axis_in  = '0;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            mul_req.start = !is_div;
            div_req.start = is_div;
            if (op_ff == OP_XP) begin
               sgn_in = vel_ext[E_W-1];
            end else if (op_ff == OP_MKP) begin
               e_in   = e_now;
               sgn_in = e_now[E_W-1];
            end else if (op_ff == OP_MKV) begin
               sgn_in = e_ff[E_W-1];
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               state_in = ST_LAUNCH;
               case (op_ff)
                  OP_PB: begin
                     pb_in = cov_add(cpv_ff, unit_val);
                     op_in = OP_APV;
                  end
                  OP_APV: begin
                     a_in  = cov_add(cpp_ff, unit_val);
                     op_in = OP_APB;
                  end
                  OP_APB: begin
                     a_in  = cov_add(cov_add(a_ff, unit_val), q48);
                     c_in  = cov_add(cvv_ff, q48);
                     op_in = OP_DKP;
                  end
                  OP_DKP: begin
                     kp_in = unit_val;
                     op_in = OP_DKV;
                  end
                  OP_DKV: begin
                     kv_in = unit_val;
                     op_in = OP_XP;
                  end
                  OP_XP: begin
                     xp_in = sat32(SUM_W'(pos_ff[axis_ff]) + sprod);
                     op_in = OP_MKP;
                  end
                  OP_MKP: begin
                     pos_in[axis_ff] = sat32(SUM_W'(xp_ff) + sprod);
                     op_in           = OP_MKV;
                  end
                  OP_MKV: begin
                     vel_in[axis_ff] = sat32(SUM_W'(vel_ff[axis_ff]) + sprod);
                     if (axis_ff == 2'd2) begin
                        op_in = OP_CPP;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                        op_in   = OP_XP;
                     end
                  end
                  OP_CPP: begin
                     cpp_in = cov_sub(a_ff, unit_val);
                     op_in  = OP_CPV;
                  end
                  OP_CPV: begin
                     cpv_in = cov_sub(pb_ff, unit_val);
                     op_in  = OP_CVV;
                  end
                  OP_CVV: begin
                     cvv_in   = cov_sub(c_ff, unit_val);
                     state_in = ST_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_OUT: begin
            // hand the positions to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.est_x = pos_ff[0];
               rsp_data_in.est_y = pos_ff[1];
               rsp_data_in.est_z = pos_ff[2];
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_PB;
         axis_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '{default: '0};
         vel_ff       <= '{default: '0};
         cpp_ff       <= COV_W'(INITIAL_ERROR_RST);
         cpv_ff       <= '0;
         cvv_ff       <= COV_W'(INITIAL_ERROR_RST);
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         axis_ff      <= axis_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         cpp_ff       <= cpp_in;
         cpv_ff       <= cpv_in;
         cvv_ff       <= cvv_in;
      end
      meas_ff     <= meas_in;
      dt_ff       <= dt_in;
      a_ff        <= a_in;
      pb_ff       <= pb_in;
      c_ff        <= c_in;
      kp_ff       <= kp_in;
      kv_ff       <= kv_in;
      xp_ff       <= xp_in;
      e_ff        <= e_in;
      sgn_ff      <= sgn_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/kcv_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcv_checker
// Port-level checks of the filter's handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`include "constant_velocity_kalman_3d_assert.svh"

module kcv_checker import kcv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result transfer holds
   `KCV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // an accepted item keeps the input stalled while it is worked on
   `KCV_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "input not stalled after transfer")

   // a new result only appears at the end of an item's work
   `KCV_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "result without work")

endmodule

bind constant_velocity_kalman_3d kcv_checker u_kcv_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Constant-velocity Kalman filter testbench
// Drives measurement items with random gaps against random result stalls and
// checks each filtered position against a cycle-free model of the filter.
// Noise and initial-error registers are rewritten between phases, extremes
// included.
// ---------------------------------------------------------------------------
module testbench;
   import kcv_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [CFG_W-1:0]  csr_pwdata;
   logic [CFG_W-1:0]  csr_prdata;
   logic              csr_pready;

   localparam logic [63:0] GAIN_PROD_CAP = 64'hFF_FFFF_FFFF;
   localparam int          SETTLE_CYCLES = 300;

   constant_velocity_kalman_3d i_dut (.*);

   // filter model state and register copies
   logic [31:0]        noise_q, noise_r, err_p0;
   bit                 flt_started;
   longint             flt_pos[3];
   longint             flt_vel[3];
   logic [COV_W-1:0]   pp, pv, vv;
   rsp_type            est_queue[$];
   int                 fail_count, sent_count, recv_count;
   bit                 no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // fixed-point model
   // ---------------------------------------------------------------------
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] cap);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (p > 128'(cap)) ? cap : p[63:0];
   endfunction

   function automatic longint fx_smul(input longint s, input logic [63:0] k);
      logic [63:0] m;
      longint      p;
      m = (s < 0) ? 64'(-s) : 64'(s);
      p = longint'(fx_mul(m, k, GAIN_PROD_CAP));
      return (s < 0) ? -p : p;
   endfunction

   function automatic logic [COV_W-1:0] cap_add(input logic [COV_W-1:0] a,
                                                input logic [COV_W-1:0] b);
      logic [63:0] s;
      s = 64'(a) + 64'(b);
      return (s > 64'(COV_MAX)) ? COV_MAX : s[COV_W-1:0];
   endfunction

   function automatic logic [COV_W-1:0] floor_sub(input logic [COV_W-1:0] a,
                                                  input logic [COV_W-1:0] b);
      return (b >= a) ? '0 : a - b;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [COV_W-1:0] gain_of(input logic [63:0] n, input logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return '0;
      q = (128'(n) << FRAC_BITS) / 128'(d);
      return (q > 128'(COV_MAX)) ? COV_MAX : q[COV_W-1:0];
   endfunction

   // one filter update; returns the expected estimate
   function automatic rsp_type filter_step(input req_type m);
      longint           meas[3];
      longint           xp, e;
      logic [63:0]      dt, s;
      logic [COV_W-1:0] pb, a, b, c, kp, kv;
      rsp_type          r;
      meas[0] = longint'(m.meas_x);
      meas[1] = longint'(m.meas_y);
      meas[2] = longint'(m.meas_z);
      dt = 64'(m.time_step);
      if (!flt_started) begin
         for (int i = 0; i < 3; i++) begin
            flt_pos[i] = meas[i];
            flt_vel[i] = 0;
         end
         pp = COV_W'(err_p0);
         pv = '0;
         vv = COV_W'(err_p0);
         flt_started = 1'b1;
      end else begin
         // predict covariance
         pb = cap_add(pv, fx_mul(dt, 64'(vv), 64'(COV_MAX)));
         a  = cap_add(pp, fx_mul(dt, 64'(pv), 64'(COV_MAX)));
         a  = cap_add(a, fx_mul(dt, 64'(pb), 64'(COV_MAX)));
         a  = cap_add(a, COV_W'(noise_q));
         b  = pb;
         c  = cap_add(vv, COV_W'(noise_q));
         s  = 64'(a) + 64'(noise_r);
         kp = gain_of(64'(a), s);
         kv = gain_of(64'(b), s);
         for (int i = 0; i < 3; i++) begin
            xp = clip32(flt_pos[i] + fx_smul(flt_vel[i], dt));
            e  = meas[i] - xp;
            flt_pos[i] = clip32(xp + fx_smul(e, 64'(kp)));
            flt_vel[i] = clip32(flt_vel[i] + fx_smul(e, 64'(kv)));
         end
         // correct covariance
         pp = floor_sub(a, COV_W'(fx_mul(64'(kp), 64'(a), 64'(COV_MAX))));
         pv = floor_sub(b, COV_W'(fx_mul(64'(kp), 64'(b), 64'(COV_MAX))));
         vv = floor_sub(c, COV_W'(fx_mul(64'(kv), 64'(b), 64'(COV_MAX))));
      end
      r.est_x = flt_pos[0][31:0];
      r.est_y = flt_pos[1][31:0];
      r.est_z = flt_pos[2][31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // driving helpers
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input req_type m);
      int gap;
      req_valid = 1'b1;
      req_data  = m;
      do @(posedge clock); while (req_stall);
      est_queue.push_back(filter_step(m));
      sent_count++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         req_data  = {$urandom, $urandom, $urandom, DT_W'($urandom)};
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = ADDR_W'({idx, 2'b00});
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (idx)
         REG_PROCESS_NOISE:     noise_q = val;
         REG_MEASUREMENT_NOISE: noise_r = val;
         REG_INITIAL_ERROR:     err_p0  = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (est_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_noise(input logic [31:0] q, input logic [31:0] r,
                            input logic [31:0] p0);
      drain();
      csr_write(REG_PROCESS_NOISE, q);
      csr_write(REG_MEASUREMENT_NOISE, r);
      csr_write(REG_INITIAL_ERROR, p0);
   endtask

   function automatic req_type make_item(input int x, input int y, input int z,
                                         input int dt);
      req_type m;
      m.meas_x    = x;
      m.meas_y    = y;
      m.meas_z    = z;
      m.time_step = DT_W'(dt);
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // first transfer is echoed; then field extremes and step corner cases
   task automatic test_directed();
      send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 20'hFFFFF));
      send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
      send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 0, 20'hFFFFF));
      send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF));
      send_item(make_item(0, 0, 0, 1));
      send_item(make_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 20'h55555));
      send_item(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 20'hAAAAA));
      send_item(make_item(100, -100, 0, 0));
   endtask

   // zero noise and zero initial error registers
   task automatic test_zero_noise();
      set_noise(0, 0, 0);
      for (int i = 0; i < 6; i++)
         send_item(make_item($urandom, $urandom, $urandom, (i % 2) ? 0 : $urandom));
   endtask

   // all registers at full scale: covariance saturation
   task automatic test_full_noise();
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++)
         send_item(make_item($urandom, $urandom, $urandom, $urandom_range(20'hFFFFF)));
   endtask

   // mostly smooth tracks with small noise, some wild measurements
   task automatic test_random(input int count);
      int pos[3], vel[3], n[3];
      int dt;
      for (int i = 0; i < 3; i++) begin
         pos[i] = $urandom_range(32'h0FFF_FFFF) - 32'h0800_0000;
         vel[i] = $urandom_range(32'h7F_FFFF) - 32'h40_0000;
      end
      for (int k = 0; k < count; k++) begin
         if (k % 50 == 0) no_idle = ($urandom_range(3) == 0);
         dt = ($urandom_range(9) == 0) ? $urandom_range(20'hFFFFF) : $urandom_range(700, 7000);
         for (int i = 0; i < 3; i++) begin
            pos[i] += int'((longint'(vel[i]) * dt) >>> 16);
            n[i] = pos[i] + $urandom_range(32'h3_FFFF) - 32'h2_0000;
         end
         if ($urandom_range(9) == 0)
            send_item(make_item($urandom, $urandom, $urandom, dt));
         else
            send_item(make_item(n[0], n[1], n[2], dt));
      end
      no_idle = 1'b0;
   endtask

   // result-side stalls, short and long bursts plus quiet stretches
   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         len = $urandom_range(99);
         if (len < 60) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end else if (len < 93) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end else begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(50, 300)) @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         recv_count++;
         if (est_queue.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            fail_count++;
         end else begin
            want = est_queue.pop_front();
            if (rsp_data.est_x !== want.est_x) report_mismatch("est_x", rsp_data.est_x, want.est_x);
            if (rsp_data.est_y !== want.est_y) report_mismatch("est_y", rsp_data.est_y, want.est_y);
            if (rsp_data.est_z !== want.est_z) report_mismatch("est_z", rsp_data.est_z, want.est_z);
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      noise_q     = PROCESS_NOISE_RST;
      noise_r     = MEASUREMENT_NOISE_RST;
      err_p0      = INITIAL_ERROR_RST;
      flt_started = 1'b0;
      pp = COV_W'(INITIAL_ERROR_RST);
      pv = '0;
      vv = COV_W'(INITIAL_ERROR_RST);
      for (int i = 0; i < 3; i++) begin
         flt_pos[i] = 0;
         flt_vel[i] = 0;
      end
      fail_count = 0;
      sent_count = 0;
      recv_count = 0;
      no_idle    = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_random(200);
      test_zero_noise();
      test_full_noise();
      set_noise(32'd1, 32'd1, 32'd1);
      test_random(150);
      set_noise($urandom_range(32'hFFFF), $urandom_range(32'h3_FFFF), $urandom);
      test_random(200);
      set_noise($urandom, $urandom, $urandom);
      test_random(200);
      drain();

      $display("covered %0d measurement transfers, %0d result transfers,", sent_count,
               recv_count);
      $display("across default, zero, full-scale and random noise settings");
      if (fail_count == 0 && est_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/kcv_pkg.sv
rtl/kcv_mul.sv
rtl/kcv_div.sv
rtl/constant_velocity_kalman_3d.sv
rtl/kcv_checker.sv
verif/testbench.sv
